### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define HFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the following edge
`define HFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hfp_pkg.sv
// ----------------------------------------------------------------------------
// hfp_pkg
// constants, types and helpers shared by the frame parser and id responder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfp_pkg;

    localparam int ID_BYTES_DEF    = 7;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [15:0] HEADER_WORD = 16'hA55A;
    localparam logic [7:0]  CMD_ID      = 8'hE4;
    localparam logic [7:0]  ID_MASK     = 8'h4A;
    localparam logic [7:0]  MIN_FRAME   = 8'd3;
    localparam logic [7:0]  CH_E        = 8'h45;
    localparam logic [7:0]  CH_3        = 8'h33;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_LF       = 8'h0A;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

### rtl/hfp_rx_if.sv
// ----------------------------------------------------------------------------
// hfp_rx_if
// valid/ready channel carrying received bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/hfp_reply_if.sv
// ----------------------------------------------------------------------------
// hfp_reply_if
// valid/ready channel carrying id reply bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hfp_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source (output valid, output reply_byte, output reply_last, input ready);
    modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

### rtl/hfp_front.sv
// ----------------------------------------------------------------------------
// hfp_front
// header hunt, frame tracking and id capture; pushes one job per id reply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfp_front #(
    parameter int ID_BYTES = hfp_pkg::ID_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    hfp_rx_if.sink                  rx,
    input  hfp_pkg::q_stat_t        q_stat,
    output logic                    push,
    output logic [ID_BYTES*8-1:0]   push_data
);
    import hfp_pkg::*;

    localparam logic [7:0] REPLY_MIN = 8'(4 + ID_BYTES);

    logic [7:0]                 pos_reg, pos_next;
    logic [7:0]                 prev_reg, prev_next;
    logic [7:0]                 total_reg, total_next;
    logic [7:0]                 cmd_reg, cmd_next;
    logic [ID_BYTES-1:0][7:0]   id_reg, id_next;
    logic                       accept;
    logic [7:0]                 pos_inc;
    logic [7:0]                 total_eff;
    logic [7:0]                 cmd_eff;
    logic [7:0]                 id_xform;

    assign rx.ready  = !q_stat.full;
    assign accept    = rx.valid && rx.ready;
    assign pos_inc   = pos_reg + 8'd1;
    assign id_xform  = reverse8(rx.rx_byte) ^ ID_MASK;
    assign total_eff = (pos_inc == 8'd3) ? (rx.rx_byte + MIN_FRAME) : total_reg;
    assign cmd_eff   = (pos_inc == 8'd4) ? rx.rx_byte : cmd_reg;
    assign push_data = id_next;

    always_comb
    begin
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        total_next = total_reg;
        cmd_next   = cmd_reg;
        id_next    = id_reg;
        push       = 1'b0;
        if (accept)
        begin
            prev_next = rx.rx_byte;
            if (pos_reg == 8'd0)
            begin
                if ({prev_reg, rx.rx_byte} == HEADER_WORD)
                begin
                    pos_next = 8'd2;
                end
            end
            else
            begin
                pos_next   = pos_inc;
                total_next = total_eff;
                cmd_next   = cmd_eff;
                for (int i = 0; i < ID_BYTES; i++)
                begin
                    if (pos_inc == 8'(5 + i))
                    begin
                        id_next[i] = id_xform;
                    end
                end
                if (pos_inc >= total_eff)
                begin
                    push       = (cmd_eff == CMD_ID) && (pos_inc >= REPLY_MIN);
                    pos_next   = 8'd0;
                    total_next = MIN_FRAME;
                    prev_next  = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 8'd0;
            prev_reg  <= 8'd0;
            total_reg <= MIN_FRAME;
            cmd_reg   <= 8'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            total_reg <= total_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

### rtl/hfp_queue.sv
// ----------------------------------------------------------------------------
// hfp_queue
// small register queue of reply jobs between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    head_data,
    output hfp_pkg::q_stat_t    q_stat
);
    import hfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/hfp_back.sv
// ----------------------------------------------------------------------------
// hfp_back
// reply sequencer: walks one job out as 'E' '3' ids CR LF through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfp_back #(
    parameter int ID_BYTES = hfp_pkg::ID_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ID_BYTES*8-1:0]   head_data,
    input  hfp_pkg::q_stat_t        q_stat,
    output logic                    pop,
    hfp_reply_if.source             reply
);
    import hfp_pkg::*;

    localparam int REPLY_LEN = ID_BYTES + 4;
    localparam int CNT_W     = $clog2(REPLY_LEN);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             advance;
    logic [7:0]       sel_byte;
    logic             sel_last;

    assign advance          = !valid_reg || reply.ready;
    assign reply.valid      = valid_reg;
    assign reply.reply_byte = byte_reg;
    assign reply.reply_last = last_reg;

    always_comb
    begin
        sel_byte = CH_E;
        sel_last = 1'b0;
        if (cnt_reg == CNT_W'(0))
        begin
            sel_byte = CH_E;
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            sel_byte = CH_3;
        end
        else if (cnt_reg == CNT_W'(ID_BYTES + 2))
        begin
            sel_byte = CH_CR;
        end
        else if (cnt_reg == CNT_W'(ID_BYTES + 3))
        begin
            sel_byte = CH_LF;
            sel_last = 1'b1;
        end
        else
        begin
            for (int i = 0; i < ID_BYTES; i++)
            begin
                if (cnt_reg == CNT_W'(i + 2))
                begin
                    sel_byte = head_data[i*8 +: 8];
                end
            end
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (advance)
        begin
            valid_next = !q_stat.empty;
            if (!q_stat.empty)
            begin
                byte_next = sel_byte;
                last_next = sel_last;
                if (sel_last)
                begin
                    cnt_next = '0;
                    pop      = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

### rtl/header_frame_parser_id_responder_unit.sv
// the last frame byte writes the job into the queue, then the back registers its first reply byte
// throughput: one rx byte per cycle; an ID_BYTES+4 byte reply leaves at one byte per cycle while ready
// the input stalls only while the two-entry reply job queue is full
// reset: rst_n asynchronous active low; parser returns to header hunt, queue and output empty
// ----------------------------------------------------------------------------
// header_frame_parser_id_responder_unit
// frame parser front, reply job queue and reply sequencer back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module header_frame_parser_id_responder_unit #(
    parameter int ID_BYTES    = hfp_pkg::ID_BYTES_DEF,
    parameter int QUEUE_DEPTH = hfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hfp_rx_if.sink      rx,
    hfp_reply_if.source reply
);
    import hfp_pkg::*;

    logic                   push;
    logic                   pop;
    logic [ID_BYTES*8-1:0]  push_data;
    logic [ID_BYTES*8-1:0]  head_data;
    q_stat_t                q_stat;

    hfp_front #(
        .ID_BYTES (ID_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    hfp_queue #(
        .WIDTH (ID_BYTES * 8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    hfp_back #(
        .ID_BYTES (ID_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_data (head_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .reply     (reply)
    );

endmodule

### rtl/hfp_checker.sv
// ----------------------------------------------------------------------------
// hfp_checker
// port-level checks on the reply channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       reply_valid,
    input logic       reply_ready,
    input logic [7:0] reply_byte,
    input logic       reply_last
);
    import hfp_pkg::*;

    `HFP_ASSERT_NEXT(a_valid_hold, reply_valid && !reply_ready, reply_valid, "reply valid dropped while stalled")
    `HFP_ASSERT_NEXT(a_data_hold, reply_valid && !reply_ready, $stable(reply_byte) && $stable(reply_last), "reply word changed while stalled")
    `HFP_ASSERT_NOW(a_last_is_lf, reply_valid && reply_last, reply_byte == CH_LF, "last word is not LF")
    `HFP_ASSERT_NEXT(a_next_starts_e, reply_valid && reply_ready && reply_last, !reply_valid || (reply_byte == CH_E && !reply_last), "reply does not open with E")

endmodule

bind header_frame_parser_id_responder_unit hfp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .reply_valid (reply.valid),
    .reply_ready (reply.ready),
    .reply_byte  (reply.reply_byte),
    .reply_last  (reply.reply_last)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the header frame parser and ID responder. Bytes go
// in on the rx channel. A behavioral copy of the parser predicts the reply
// words. A short table of directed frames comes first; where a reply is obvious
// the known reply is typed in and used instead of the prediction. Random frames
// follow, mostly well formed with some noise, under three idling mixes and one
// long hold on the reply side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import hfp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int ID_N         = ID_BYTES_DEF;
    localparam int RANDOM_ITEMS = 345;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_N        = 26;

    localparam logic [7:0] HDR_HI = HEADER_WORD[15:8];
    localparam logic [7:0] HDR_LO = HEADER_WORD[7:0];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_word_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic       gives;
        logic [7:0] id_out;
    } stim_row_t;

    // typed rows carry the known reply, the rest go through the parser copy
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{HDR_HI, 1'b0, 1'b0, 8'h00},
        '{HDR_LO, 1'b0, 1'b0, 8'h00},
        '{8'h01,  1'b0, 1'b0, 8'h00},
        '{HDR_HI, 1'b1, 1'b0, 8'h00},
        '{HDR_LO, 1'b1, 1'b0, 8'h00},
        '{HDR_HI, 1'b0, 1'b0, 8'h00},
        '{HDR_LO, 1'b0, 1'b0, 8'h00},
        '{8'h0A,  1'b0, 1'b0, 8'h00},
        '{CMD_ID, 1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b0, 1'b0, 8'h00},
        '{HDR_HI, 1'b0, 1'b0, 8'h00},
        '{HDR_LO, 1'b1, 1'b1, 8'hB5},
        '{HDR_HI, 1'b0, 1'b0, 8'h00},
        '{HDR_LO, 1'b0, 1'b0, 8'h00},
        '{8'h02,  1'b0, 1'b0, 8'h00},
        '{CMD_ID, 1'b0, 1'b0, 8'h00},
        '{8'h00,  1'b1, 1'b0, 8'h00},
        '{HDR_HI, 1'b0, 1'b0, 8'h00},
        '{HDR_LO, 1'b0, 1'b0, 8'h00},
        '{8'hFF,  1'b1, 1'b0, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;

    hfp_rx_if    rx_ch();
    hfp_reply_if reply_ch();

    header_frame_parser_id_responder_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .reply (reply_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // parser copy
    logic [15:0] hunt_shift;
    int unsigned frame_pos;
    logic [7:0]  frame_len;
    logic [7:0]  frame_cmd;
    logic [7:0]  id_seen [ID_N];

    reply_word_t predicted_reply [$];
    reply_word_t expected_reply [$];

    int  src_idle_pct  = 6;
    int  sink_idle_pct = 59;
    bit  squeeze_go    = 1'b0;
    bit  broken        = 1'b0;
    int  rx_count      = 0;
    int  stall_cycles  = 0;

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] flipped;
        int         i;
        int         k;
        hunt_shift = {hunt_shift[7:0], b};
        if (frame_pos == 0)
        begin
            if (hunt_shift == HEADER_WORD)
                frame_pos = 2;
        end
        else
        begin
            frame_pos++;
            if (frame_pos == 3)
                frame_len = b + MIN_FRAME;
            if (frame_pos == 4)
                frame_cmd = b;
            if (frame_pos >= 5 && frame_pos - 5 < ID_N)
                id_seen[frame_pos - 5] = b;
            if (frame_pos >= frame_len)
            begin
                if (frame_cmd == CMD_ID && frame_pos >= 4 + ID_N)
                begin
                    predicted_reply.push_back('{CH_E, 1'b0});
                    predicted_reply.push_back('{CH_3, 1'b0});
                    for (i = 0; i < ID_N; i++)
                    begin
                        for (k = 0; k < 8; k++)
                            flipped[k] = id_seen[i][7-k];
                        predicted_reply.push_back('{flipped ^ ID_MASK, 1'b0});
                    end
                    predicted_reply.push_back('{CH_CR, 1'b0});
                    predicted_reply.push_back('{CH_LF, 1'b1});
                end
                frame_pos  = 0;
                frame_len  = MIN_FRAME;
                hunt_shift = '0;
            end
        end
    endtask

    task automatic send_rx(input logic [7:0] b, input logic typed = 1'b0,
                           input logic gives = 1'b0, input logic [7:0] id_out = 8'h00);
        int i;
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        rx_count++;
        parse_rx_byte(b);
        if (typed)
        begin
            if (gives)
            begin
                expected_reply.push_back('{CH_E, 1'b0});
                expected_reply.push_back('{CH_3, 1'b0});
                for (i = 0; i < ID_N; i++)
                    expected_reply.push_back('{id_out, 1'b0});
                expected_reply.push_back('{CH_CR, 1'b0});
                expected_reply.push_back('{CH_LF, 1'b1});
            end
        end
        else
        begin
            foreach (predicted_reply[i])
                expected_reply.push_back(predicted_reply[i]);
        end
        predicted_reply.delete();
        @(negedge clk);
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        logic [7:0]  len_byte;
        logic [7:0]  cmd;
        int          total;
        int          i;
        pick = $urandom_range(99);
        if (pick >= 84)
        begin
            // stray bytes while hunting, often a lone header half
            repeat ($urandom_range(1, 4))
                send_rx(($urandom_range(2) == 0) ? HDR_HI : 8'($urandom_range(255)));
            return;
        end
        cmd = CMD_ID;
        if (pick < 55)
            len_byte = ($urandom_range(9) == 0) ? 8'($urandom_range(9, 45))
                                                : 8'($urandom_range(ID_N + 1, ID_N + 5));
        else if (pick < 70)
        begin
            cmd = 8'($urandom_range(255));
            if (cmd == CMD_ID)
                cmd = ~cmd;
            len_byte = 8'($urandom_range(1, 20));
        end
        else if (pick < 78)
            len_byte = 8'($urandom_range(1, ID_N));
        else
            len_byte = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(253, 255));
        total = 8'(len_byte + MIN_FRAME);
        if (total < MIN_FRAME)
            total = MIN_FRAME;
        send_rx(HDR_HI);
        send_rx(HDR_LO);
        send_rx(len_byte);
        if (total >= 4)
            send_rx(cmd);
        for (i = 4; i < total; i++)
        begin
            case ($urandom_range(15))
                0:       send_rx(HDR_HI);
                1:       send_rx(HDR_LO);
                default: send_rx(8'($urandom_range(255)));
            endcase
        end
    endtask

    initial
    begin : reply_sink
        int hold_left;
        bit squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        reply_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_go && !squeezed)
            begin
                squeezed  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                reply_ch.ready <= 1'b0;
            end
            else
                reply_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : reply_check
        reply_word_t want;
        if (rst_n && reply_ch.valid && reply_ch.ready)
        begin
            if (expected_reply.size() == 0)
            begin
                $display("%0t reply word with none expected: expected none, actual %h/%b",
                         $time, reply_ch.reply_byte, reply_ch.reply_last);
                broken = 1'b1;
            end
            else
            begin
                want = expected_reply.pop_front();
                if (reply_ch.reply_byte !== want.data)
                begin
                    $display("%0t reply_byte mismatch: expected %h, actual %h",
                             $time, want.data, reply_ch.reply_byte);
                    broken = 1'b1;
                end
                if (reply_ch.reply_last !== want.last)
                begin
                    $display("%0t reply_last mismatch: expected %b, actual %b",
                             $time, want.last, reply_ch.reply_last);
                    broken = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (reply_ch.valid && reply_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int p;
        int r;
        int target;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        hunt_shift    = '0;
        frame_pos     = 0;
        frame_len     = MIN_FRAME;
        frame_cmd     = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < DIR_N; r++)
            send_rx(DIR_ROWS[r].rx, DIR_ROWS[r].typed, DIR_ROWS[r].gives, DIR_ROWS[r].id_out);

        for (p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct  = 6;
                    sink_idle_pct = 59;
                end
                1:
                begin
                    src_idle_pct  = 59;
                    sink_idle_pct = 6;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    squeeze_go    = 1'b1;
                end
            endcase
            target = rx_count + RANDOM_ITEMS / 3;
            while (rx_count < target)
                send_random_frame();
        end
        rx_ch.valid <= 1'b0;

        while (expected_reply.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!broken)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
